// ----- hdl/image_downscale_2x2_gray_depth_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 downscale core
// Shorthand for clocked implication checks, sampled on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_DOWNSCALE_2X2_GRAY_DEPTH_CORE_MACROS_SVH
`define IMAGE_DOWNSCALE_2X2_GRAY_DEPTH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/idg_pkg.sv -----
// ----------------------------------------------------------------------------
// idg_pkg
// Types and constants shared by the 2x2 downscale controller and datapath.
// ----------------------------------------------------------------------------
package idg_pkg;

  localparam int unsigned PixW = 16;

  // Register indexes on the configuration channel.
  localparam logic [1:0] RegDepthMode = 2'd0;
  localparam logic [1:0] RegOutWidth  = 2'd1;
  localparam logic [1:0] RegOutHeight = 2'd2;
  localparam logic [1:0] RegRowPixels = 2'd3;

  localparam logic [9:0]  OutWidthRst  = 10'd320;
  localparam logic [9:0]  OutHeightRst = 10'd240;
  localparam logic [10:0] RowPixelsRst = 11'd640;

  // floor(x / 3) == (x * Recip3) >> Recip3Shift for every 18-bit x.
  localparam logic [17:0] Recip3      = 18'd174763;
  localparam int unsigned Recip3Shift = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic        depth_mode;
    logic [9:0]  out_width;
    logic [9:0]  out_height;
    logic [10:0] row_pixels;
  } cfg_t;

  typedef struct packed {
    logic accept;    // take the input beat
    logic sum_load;  // combine line entry with the current pair
    logic out_load;  // load the averaged pixel into the output register
  } cmd_t;

  typedef struct packed {
    logic produce;   // the pending input beat completes a 2x2 block
    logic out_free;  // output register can take a new beat
  } status_t;

endpackage

// ----- hdl/image_downscale_2x2_gray_depth_core.sv -----
// ----------------------------------------------------------------------------
// image_downscale_2x2_gray_depth_core
// Halves a raster pixel stream in both directions by 2x2 averaging.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one per beat, with
// row_pixels pixels per row; only the first 2*out_width pixels of a row and
// the first 2*out_height rows of a frame are used. One averaged pixel leaves
// on m_axis for each 2x2 block, with tlast on the last pixel of an output row
// and tuser on the last pixel of the frame.
// Gray mode averages the low 8 bits of the four pixels; depth mode averages
// only the nonzero pixels and gives 0 when all four are zero.
// A pixel that completes a block steps on through the registered line buffer
// read, the block sum, and the mean with its output load; no new pixel is
// taken until those steps are done. The output register lets the next pixels
// be taken while a result waits; a stalled receiver holds the block in its
// final step until the register frees, and input is then held off.
// Registers must be written on the cfg channel while the stream is idle; the
// block itself does not enforce this, so the user is bound to keep to it.
// Reset returns the registers to gray mode, 320x240 output, 640-pixel rows,
// and puts the raster position at the top left of a frame. Line buffer
// entries are written on the even row before they are read.
// ----------------------------------------------------------------------------
`include "image_downscale_2x2_gray_depth_core_macros.svh"

module image_downscale_2x2_gray_depth_core #(
  parameter int unsigned MAX_OUT_WIDTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_pixel
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import idg_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_mode <= 1'b0;
      cfg_q.out_width  <= OutWidthRst;
      cfg_q.out_height <= OutHeightRst;
      cfg_q.row_pixels <= RowPixelsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDepthMode: cfg_q.depth_mode <= cfg_data_i[0];
        RegOutWidth:  cfg_q.out_width  <= cfg_data_i[9:0];
        RegOutHeight: cfg_q.out_height <= cfg_data_i[9:0];
        RegRowPixels: cfg_q.row_pixels <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  idg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  idg_dp #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_i     (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .row_end_o   (m_axis_tlast),
    .frame_end_o (m_axis_tuser)
  );

  `IDG_ASSERT_SAME(a_out_load_free, cmd.out_load, status.out_free, "output overwritten")
  `IDG_ASSERT_NEXT(a_block_sums, cmd.accept && status.produce, cmd.sum_load, "block sum skipped")
  `IDG_ASSERT_SAME(a_no_accept_busy, cmd.sum_load, !s_axis_tready, "input taken while busy")
  `IDG_ASSERT_SAME(a_frame_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end without row end")

endmodule

// ----- hdl/idg_ctrl.sv -----
// ----------------------------------------------------------------------------
// idg_ctrl
// Sequencer: accepts pixels and steps block-completing pixels through the
// line read, the sum and the averaging stage.
// ----------------------------------------------------------------------------
module idg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  idg_pkg::status_t status_i,
  output idg_pkg::cmd_t    cmd_o
);
  import idg_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.produce) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_load = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/idg_dp.sv -----
// ----------------------------------------------------------------------------
// idg_dp
// Datapath: raster counters, held even-column pixel, line buffer of pair
// sums, block sum, mean and the output register.
// ----------------------------------------------------------------------------
module idg_dp #(
  parameter int unsigned MAX_OUT_WIDTH = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  idg_pkg::cfg_t    cfg_i,
  input  idg_pkg::cmd_t    cmd_i,
  output idg_pkg::status_t status_o,
  input  logic [15:0]      pixel_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [15:0]      out_pixel_o,
  output logic             row_end_o,
  output logic             frame_end_o
);
  import idg_pkg::*;

  localparam int unsigned AddrW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  // Effective (clamped) limits.
  logic [9:0]  w_eff, h_eff;
  logic [10:0] rl_eff, two_w, two_h;

  always_comb begin
    if (cfg_i.out_width == 10'd0) begin
      w_eff = 10'd1;
    end else if ({3'b0, cfg_i.out_width} > 13'(MAX_OUT_WIDTH)) begin
      w_eff = 10'(MAX_OUT_WIDTH);
    end else begin
      w_eff = cfg_i.out_width;
    end
    if (cfg_i.out_height == 10'd0) begin
      h_eff = 10'd1;
    end else if (cfg_i.out_height > 10'd512) begin
      h_eff = 10'd512;
    end else begin
      h_eff = cfg_i.out_height;
    end
    if (cfg_i.row_pixels < 11'd2) begin
      rl_eff = 11'd2;
    end else if (cfg_i.row_pixels > 11'd1024) begin
      rl_eff = 11'd1024;
    end else begin
      rl_eff = cfg_i.row_pixels;
    end
  end

  assign two_w = {w_eff, 1'b0};
  assign two_h = {h_eff, 1'b0};

  logic [9:0] col_q, row_q;
  logic       in_used, odd_col, odd_row;

  assign in_used = ({1'b0, col_q} < two_w) && ({1'b0, row_q} < two_h);
  assign odd_col = col_q[0];
  assign odd_row = row_q[0];

  assign status_o.produce  = in_used && odd_col && odd_row;
  assign status_o.out_free = !out_valid_o || out_ready_i;

  // Raster position of the next pixel.
  logic [10:0] col_inc, row_inc;
  assign col_inc = {1'b0, col_q} + 11'd1;
  assign row_inc = {1'b0, row_q} + 11'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (col_inc >= rl_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= two_h) ? 10'd0 : row_inc[9:0];
      end else begin
        col_q <= col_inc[9:0];
      end
    end
  end

  // Pixel value and validity for the current mode.
  logic [15:0] pix_val;
  logic        pix_vld;
  assign pix_val = cfg_i.depth_mode ? pixel_i : {8'd0, pixel_i[7:0]};
  assign pix_vld = cfg_i.depth_mode ? (pixel_i != 16'd0) : 1'b1;

  logic [15:0] held_val_q;
  logic        held_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_val_q <= '0;
      held_vld_q <= 1'b0;
    end else if (cmd_i.accept && in_used && !odd_col) begin
      held_val_q <= pix_val;
      held_vld_q <= pix_vld;
    end
  end

  logic [16:0] pair_sum;
  logic [1:0]  pair_cnt;
  assign pair_sum = {1'b0, held_val_q} + {1'b0, pix_val};
  assign pair_cnt = {1'b0, held_vld_q} + {1'b0, pix_vld};

  logic [AddrW-1:0] addr;
  assign addr = AddrW'(col_q[9:1]);

  // Line buffer: {count, pair sum} per output column, written on even rows.
  logic [18:0] line_mem [MAX_OUT_WIDTH];
  logic [18:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_used && odd_col && !odd_row) begin
      line_mem[addr] <= {pair_cnt, pair_sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.produce) begin
      line_rd_q <= line_mem[addr];
    end
  end

  logic [16:0] pair_sum_q;
  logic [1:0]  pair_cnt_q;
  logic        re_q, fe_q;
  logic        re_cur;
  assign re_cur = ({1'b0, col_q[9:1]} == (w_eff - 10'd1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.produce) begin
      pair_sum_q <= pair_sum;
      pair_cnt_q <= pair_cnt;
      re_q       <= re_cur;
      fe_q       <= re_cur && ({1'b0, row_q[9:1]} == (h_eff - 10'd1));
    end
  end

  // Block sum and valid count.
  logic [17:0] blk_sum_q;
  logic [2:0]  blk_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_load) begin
      blk_sum_q <= {1'b0, line_rd_q[16:0]} + {1'b0, pair_sum_q};
      blk_cnt_q <= {1'b0, line_rd_q[18:17]} + {1'b0, pair_cnt_q};
    end
  end

  // Mean: division by 3 goes through a reciprocal multiply.
  logic [35:0] prod3;
  logic [15:0] mean;
  assign prod3 = blk_sum_q * Recip3;

  always_comb begin
    if (!cfg_i.depth_mode) begin
      mean = blk_sum_q[17:2];
    end else begin
      case (blk_cnt_q)
        3'd1:    mean = blk_sum_q[15:0];
        3'd2:    mean = blk_sum_q[16:1];
        3'd3:    mean = prod3[Recip3Shift+15:Recip3Shift];
        3'd4:    mean = blk_sum_q[17:2];
        default: mean = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_o <= mean;
      row_end_o   <= re_q;
      frame_end_o <= fe_q;
    end
  end

endmodule
